// ===== src/tensor_permute_index_gen_core_assert.svh =====
// Assertion macros for the permute index generator.
// Each expects clk_i and rst_ni in the scope where it is used.
`ifndef TENSOR_PERMUTE_INDEX_GEN_CORE_ASSERT_SVH
`define TENSOR_PERMUTE_INDEX_GEN_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// ante holds -> cons holds in the same cycle
`define TPIG_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// ante holds -> cons holds later, after the delay given by n
`define TPIG_ASSERT_DELAY(lbl, ante, n, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##n (cons)) \
    else $error(msg);

`else

`define TPIG_ASSERT_IMPLIES(lbl, ante, cons, msg)
`define TPIG_ASSERT_DELAY(lbl, ante, n, cons, msg)

`endif

`endif

// ===== src/tpig_pkg.sv =====
`timescale 1ns / 1ps

package tpig_pkg;

  localparam int MAX_AXES   = 4;
  localparam int DIM_BITS   = 16;
  localparam int ORDER_BITS = 2;
  localparam int LIN_BITS   = 32;
  localparam int IDX_BITS   = 34;
  localparam int CFG_BITS   = 64;
  localparam int AXC_BITS   = 3;
  localparam int ORD_REG_BITS = 8;
  localparam int CFG_IDX_BITS = 3;

  // one restoring division step per quotient bit, plus two weigh stages
  localparam int AXIS_STAGES = LIN_BITS + 2;
  localparam int LATENCY     = 1 + MAX_AXES * AXIS_STAGES;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_ELEMENT_COUNT = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_AXIS_COUNT    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_AXIS_ORDER    = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_DST_EXTENTS   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_DST_STRIDES   = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_SRC_STRIDES   = 3'd5;

  // reset values
  localparam logic [LIN_BITS-1:0]     RST_ELEMENT_COUNT = '0;
  localparam logic [AXC_BITS-1:0]     RST_AXIS_COUNT    = 3'd1;
  localparam logic [ORD_REG_BITS-1:0] RST_AXIS_ORDER    = 8'hE4;
  localparam logic [CFG_BITS-1:0]     RST_DST_EXTENTS   = 64'h0001_0001_0001_0001;

  // payload carried down the cell chain
  typedef struct packed {
    logic [LIN_BITS-1:0] dvd;     // dividend in, quotient shifted in
    logic [DIM_BITS-1:0] rem;     // partial remainder, digit at axis end
    logic [IDX_BITS-1:0] src;
    logic [IDX_BITS-1:0] dst;
    logic                in_range;
    logic                cfg_err;
  } tpig_pay_t;

  typedef struct packed {
    logic      valid;
    tpig_pay_t pay;
  } tpig_beat_t;

  // DIM_BITS-wide field pos of a 64-bit register; fields past the top read 0
  function automatic logic [DIM_BITS-1:0] dim_field(input logic [CFG_BITS-1:0] r,
                                                    input int unsigned pos);
    logic [CFG_BITS-1:0] s;
    s = '0;
    if (pos * DIM_BITS < CFG_BITS) begin
      s = r >> (pos * DIM_BITS);
    end
    return s[DIM_BITS-1:0];
  endfunction

endpackage

// ===== src/tpig_div_cell.sv =====
`timescale 1ns / 1ps

// One restoring division step: yields one quotient bit.
module tpig_div_cell
  import tpig_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [DIM_BITS-1:0] ext_i,
  input  tpig_beat_t          beat_i,
  output tpig_beat_t          beat_o
);

  logic            valid_q;
  tpig_pay_t       pay_q, pay_d;
  logic [DIM_BITS:0] trial, diff;
  logic            ge;

  always_comb begin
    trial = {beat_i.pay.rem, beat_i.pay.dvd[LIN_BITS-1]};
    ge    = (trial >= {1'b0, ext_i});
    diff  = trial - {1'b0, ext_i};
    pay_d = beat_i.pay;
    pay_d.rem = ge ? diff[DIM_BITS-1:0] : trial[DIM_BITS-1:0];
    pay_d.dvd = {beat_i.pay.dvd[LIN_BITS-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= beat_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    pay_q <= pay_d;
  end

  assign beat_o = '{valid: valid_q, pay: pay_q};

endmodule

// ===== src/tpig_weigh_cell.sv =====
`timescale 1ns / 1ps

// Weighs the axis digit by both strides (stage 1) and accumulates (stage 2).
module tpig_weigh_cell
  import tpig_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [DIM_BITS-1:0] dst_stride_i,
  input  logic [DIM_BITS-1:0] src_stride_i,
  input  tpig_beat_t          beat_i,
  output tpig_beat_t          beat_o
);

  logic                  v1_q, v2_q;
  tpig_pay_t             pay1_q, pay2_q, pay2_d;
  logic [2*DIM_BITS-1:0] pd_q, ps_q, pd_d, ps_d;

  assign pd_d = (2*DIM_BITS)'(beat_i.pay.rem) * (2*DIM_BITS)'(dst_stride_i);
  assign ps_d = (2*DIM_BITS)'(beat_i.pay.rem) * (2*DIM_BITS)'(src_stride_i);

  always_comb begin
    pay2_d     = pay1_q;
    pay2_d.dst = pay1_q.dst + IDX_BITS'(pd_q);
    pay2_d.src = pay1_q.src + IDX_BITS'(ps_q);
    pay2_d.rem = '0;   // next axis starts with an empty remainder
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= beat_i.valid;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pay1_q <= beat_i.pay;
    pd_q   <= pd_d;
    ps_q   <= ps_d;
    pay2_q <= pay2_d;
  end

  assign beat_o = '{valid: v2_q, pay: pay2_q};

endmodule

// ===== src/tpig_axis.sv =====
`timescale 1ns / 1ps

// One axis: LIN_BITS division cells in a row, then the weigh cell.
module tpig_axis
  import tpig_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [DIM_BITS-1:0] ext_i,
  input  logic [DIM_BITS-1:0] dst_stride_i,
  input  logic [DIM_BITS-1:0] src_stride_i,
  input  tpig_beat_t          beat_i,
  output tpig_beat_t          beat_o
);

  tpig_beat_t chain [LIN_BITS+1];

  assign chain[0] = beat_i;

  for (genvar g = 0; g < LIN_BITS; g++) begin : g_div
    tpig_div_cell u_div (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ext_i  (ext_i),
      .beat_i (chain[g]),
      .beat_o (chain[g+1])
    );
  end

  tpig_weigh_cell u_weigh (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .dst_stride_i (dst_stride_i),
    .src_stride_i (src_stride_i),
    .beat_i       (chain[LIN_BITS]),
    .beat_o       (beat_o)
  );

endmodule

// ===== src/tensor_permute_index_gen_core.sv =====
// Permute address generator. Each beat taken on start (busy never rises, so a
// beat may be taken every cycle) carries one linear output element number; its
// source and destination element offsets come out on done_o in order, one
// result per beat and one beat per cycle sustained. The receiver cannot
// stall: a result is on the ports for the single cycle that done_o is high
// and must be taken then. Each beat passes through a chain of registered
// cells: one entry register, then per axis 32 restoring division cells (one
// quotient bit each) and two weigh stages (stride multiply, then accumulate).
// Configuration is written through the cfg port, always ready, and must only
// change while no beat is in flight.
`timescale 1ns / 1ps
`include "tensor_permute_index_gen_core_assert.svh"

module tensor_permute_index_gen_core
  import tpig_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,

  // item channel
  input  logic                    start,
  output logic                    busy,
  input  logic [LIN_BITS-1:0]     linear_index_i,

  // result channel
  output logic                    done_o,
  output logic [IDX_BITS-1:0]     src_index_o,
  output logic [IDX_BITS-1:0]     dst_index_o,
  output logic                    in_range_o,
  output logic                    config_error_o,

  // configuration write channel
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [CFG_BITS-1:0]     cfg_data_i
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [LIN_BITS-1:0]     element_count_q;
  logic [AXC_BITS-1:0]     axis_count_q;
  logic [ORD_REG_BITS-1:0] axis_order_q;
  logic [CFG_BITS-1:0]     dst_extents_q, dst_strides_q, src_strides_q;
  logic                    cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      element_count_q <= RST_ELEMENT_COUNT;
      axis_count_q    <= RST_AXIS_COUNT;
      axis_order_q    <= RST_AXIS_ORDER;
      dst_extents_q   <= RST_DST_EXTENTS;
      dst_strides_q   <= '0;
      src_strides_q   <= '0;
    end else if (cfg_we) begin
      case (cfg_index_i)
        REG_ELEMENT_COUNT: element_count_q <= cfg_data_i[LIN_BITS-1:0];
        REG_AXIS_COUNT:    axis_count_q    <= cfg_data_i[AXC_BITS-1:0];
        REG_AXIS_ORDER:    axis_order_q    <= cfg_data_i[ORD_REG_BITS-1:0];
        REG_DST_EXTENTS:   dst_extents_q   <= cfg_data_i;
        REG_DST_STRIDES:   dst_strides_q   <= cfg_data_i;
        REG_SRC_STRIDES:   src_strides_q   <= cfg_data_i;
        default: ;         // unmapped index: write is dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Per-axis operands. The user keeps config static while beats are in flight
  // (the block does not enforce it), so each section reads its fields straight
  // from the registers. Unused axes divide by one, weigh by zero: pass untouched.
  // ---------------------------------------------------------------------------
  logic [MAX_AXES-1:0] in_use, ext_zero;
  logic [DIM_BITS-1:0] ax_ext [MAX_AXES];
  logic [DIM_BITS-1:0] ax_dst [MAX_AXES];
  logic [DIM_BITS-1:0] ax_src [MAX_AXES];
  logic                cfg_err;

  for (genvar a = 0; a < MAX_AXES; a++) begin : g_ops
    logic [DIM_BITS-1:0]   ext, dstr, sstr;
    logic [ORDER_BITS-1:0] ord;
    logic [CFG_BITS-1:0]   order_wide;

    assign order_wide = CFG_BITS'(axis_order_q);
    assign ord        = order_wide[a*ORDER_BITS +: ORDER_BITS];
    assign ext        = dim_field(dst_extents_q, a);
    assign dstr       = dim_field(dst_strides_q, a);
    // order field naming a nonexistent axis picks a zero stride
    assign sstr       = (int'(ord) < MAX_AXES) ? dim_field(src_strides_q, int'(ord)) : '0;

    // axis a is in use when a < min(axis_count, MAX_AXES), i.e. a < axis_count
    assign in_use[a]   = int'(axis_count_q) > a;
    assign ext_zero[a] = (ext == '0);

    assign ax_ext[a] = in_use[a] ? ext  : DIM_BITS'(1);
    assign ax_dst[a] = in_use[a] ? dstr : '0;
    assign ax_src[a] = in_use[a] ? sstr : '0;
  end

  assign cfg_err = |(in_use & ext_zero);

  // ---------------------------------------------------------------------------
  // Entry register: one beat per cycle, range check done here
  // ---------------------------------------------------------------------------
  logic       acc;
  logic       in_valid_q;
  tpig_pay_t  in_pay_q, in_pay_d;
  tpig_beat_t sec [MAX_AXES+1];

  assign busy = 1'b0;   // chain advances every cycle, nothing ever blocks it
  assign acc  = start && !busy;

  always_comb begin
    in_pay_d          = '0;
    in_pay_d.dvd      = linear_index_i;
    in_pay_d.in_range = linear_index_i < element_count_q;
    in_pay_d.cfg_err  = cfg_err;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= acc;
    end
  end

  always_ff @(posedge clk_i) begin
    in_pay_q <= in_pay_d;
  end

  assign sec[0] = '{valid: in_valid_q, pay: in_pay_q};

  // ---------------------------------------------------------------------------
  // Axis sections, last axis first: section s peels digit of axis
  // MAX_AXES-1-s and hands the quotient on to the next section.
  // ---------------------------------------------------------------------------
  for (genvar s = 0; s < MAX_AXES; s++) begin : g_sec
    tpig_axis u_axis (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ext_i        (ax_ext[MAX_AXES-1-s]),
      .dst_stride_i (ax_dst[MAX_AXES-1-s]),
      .src_stride_i (ax_src[MAX_AXES-1-s]),
      .beat_i       (sec[s]),
      .beat_o       (sec[s+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Result: indices forced to zero when out of range or config is bad
  // ---------------------------------------------------------------------------
  tpig_beat_t res;
  logic       kill;

  assign res            = sec[MAX_AXES];
  assign kill           = res.pay.cfg_err || !res.pay.in_range;
  assign done_o         = res.valid;
  assign src_index_o    = kill ? '0 : res.pay.src;
  assign dst_index_o    = kill ? '0 : res.pay.dst;
  assign in_range_o     = res.pay.in_range;
  assign config_error_o = res.pay.cfg_err;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `TPIG_ASSERT_DELAY(a_beat_emerges, acc, LATENCY, done_o, "accepted beat lost in chain")
  `TPIG_ASSERT_IMPLIES(a_no_orphan, done_o, $past(acc, LATENCY), "result without a beat")
  `TPIG_ASSERT_IMPLIES(a_zero_on_fault, done_o && (config_error_o || !in_range_o),
                       (src_index_o == '0) && (dst_index_o == '0), "fault result not zeroed")

endmodule
